[design/packed_vertex_decode_core_assert.svh]
// ----------------------------------------------------------------------------
// packed_vertex_decode_core assertion macros
// Concurrent assertion wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PACKED_VERTEX_DECODE_CORE_ASSERT_SVH
`define PACKED_VERTEX_DECODE_CORE_ASSERT_SVH

`ifndef SYNTH
`define PVD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PVD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PVD_ASSERT(lbl, clk, rst_n, prop, msg)
`define PVD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/pvd_pkg.sv]
// ----------------------------------------------------------------------------
// pvd_pkg
// Widths, fixed-point constants and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package pvd_pkg;

  localparam int NORMAL_FRAC_BITS = 14;

  localparam int COORD_W   = 16;
  localparam int SCALE_W   = 24;
  localparam int POS_W     = 30;
  localparam int NORM_W    = 16;
  localparam int ANGLE_W   = 8;
  localparam int HALF_W    = 16;
  localparam int INDEX_W   = 9;
  localparam int POS_SHIFT = 10;
  localparam int PROD_W    = COORD_W + SCALE_W + 1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

  // Q1.F sine value: sign, integer bit, F fraction bits
  localparam int SIN_W      = NORMAL_FRAC_BITS + 2;
  localparam int NPROD_W    = 2 * SIN_W;
  localparam int QTR_STEPS  = 1 << (ANGLE_W - 2);
  localparam int QTR_N      = QTR_STEPS + 1;
  localparam int QIDX_W     = ANGLE_W - 1;
  localparam int NORM_ONE   = 1 << NORMAL_FRAC_BITS;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  typedef logic [SIN_W-2:0]            qmag_t;
  typedef qmag_t [QTR_N-1:0]           qtr_table_t;

  // (a * b) >> 60 in unsigned Q4.60
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Taylor series sine, evaluated at elaboration only
  function automatic logic [63:0] sine_q60(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 14; n++) begin
      term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic qtr_table_t build_qtr();
    qtr_table_t  t;
    logic [63:0] v;
    for (int k = 0; k < QTR_N; k++) begin
      v = sine_q60((PI_Q60 >> 7) * 64'(k));
      v = (v + (64'd1 << (59 - NORMAL_FRAC_BITS))) >> (60 - NORMAL_FRAC_BITS);
      t[k] = v[SIN_W-2:0];
    end
    return t;
  endfunction

  localparam qtr_table_t SIN_QTR = build_qtr();

  // Full-wave sine from the quarter table by symmetry
  function automatic logic signed [SIN_W-1:0] sin_lookup(input logic [ANGLE_W-1:0] a);
    logic [QIDX_W-1:0] r;
    logic [QIDX_W-1:0] step;
    qmag_t             m;
    step = {1'b0, a[ANGLE_W-3:0]};
    r    = a[ANGLE_W-2] ? (QIDX_W'(QTR_STEPS) - step) : step;
    m    = SIN_QTR[r];
    return a[ANGLE_W-1] ? -signed'({1'b0, m}) : signed'({1'b0, m});
  endfunction

endpackage

[design/pvd_pos_scale.sv]
// ----------------------------------------------------------------------------
// pvd_pos_scale
// Scales one signed coordinate by the Q8.16 mesh scale, divides by 1024,
// rounds to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module pvd_pos_scale
  import pvd_pkg::*;
(
  input  logic signed [COORD_W-1:0] coord,
  input  logic        [SCALE_W-1:0] scale,
  output logic signed [POS_W-1:0]   pos
);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;

  always_comb begin
    prod = PROD_W'(coord) * PROD_W'(signed'({1'b0, scale}));
    rnd  = prod + (prod[PROD_W-1] ? PROD_W'((1 << (POS_SHIFT - 1)) - 1)
                                  : PROD_W'(1 << (POS_SHIFT - 1)));
  end

  assign pos = rnd[POS_SHIFT +: POS_W];

endmodule

[design/pvd_normal.sv]
// ----------------------------------------------------------------------------
// pvd_normal
// Normal vector from azimuth and elevation through the sine table.
// ----------------------------------------------------------------------------
module pvd_normal
  import pvd_pkg::*;
(
  input  logic        [ANGLE_W-1:0] azimuth,
  input  logic        [ANGLE_W-1:0] elevation,
  output logic signed [NORM_W-1:0]  normal_x,
  output logic signed [NORM_W-1:0]  normal_y,
  output logic signed [NORM_W-1:0]  normal_z
);

  localparam logic [ANGLE_W-1:0] QUARTER = ANGLE_W'(QTR_STEPS);
  localparam logic signed [NPROD_W-1:0] HALF_LSB = NPROD_W'(1 << (NORMAL_FRAC_BITS - 1));

  logic signed [SIN_W-1:0]   sin_az;
  logic signed [SIN_W-1:0]   cos_az;
  logic signed [SIN_W-1:0]   sin_el;
  logic signed [SIN_W-1:0]   cos_el;
  logic signed [NPROD_W-1:0] px;
  logic signed [NPROD_W-1:0] py;
  logic signed [NPROD_W-1:0] rx;
  logic signed [NPROD_W-1:0] ry;
  logic signed [NPROD_W-1:0] sx;
  logic signed [NPROD_W-1:0] sy;

  always_comb begin
    sin_az = sin_lookup(azimuth);
    cos_az = sin_lookup(azimuth + QUARTER);
    sin_el = sin_lookup(elevation);
    cos_el = sin_lookup(elevation + QUARTER);
    px = NPROD_W'(sin_az) * NPROD_W'(cos_el);
    py = NPROD_W'(cos_az) * NPROD_W'(cos_el);
    // ties away from zero
    rx = px + (px[NPROD_W-1] ? HALF_LSB - NPROD_W'(1) : HALF_LSB);
    ry = py + (py[NPROD_W-1] ? HALF_LSB - NPROD_W'(1) : HALF_LSB);
    sx = rx >>> NORMAL_FRAC_BITS;
    sy = ry >>> NORMAL_FRAC_BITS;
  end

  assign normal_x = NORM_W'(sx);
  assign normal_y = NORM_W'(sy);
  assign normal_z = NORM_W'(sin_el);

endmodule

[design/packed_vertex_decode_core.sv]
// ----------------------------------------------------------------------------
// packed_vertex_decode_core
// Packed mesh vertex decoder: scaled positions, table normals, vertex index.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one packed vertex per transaction:
//   three signed coordinates, two 8-bit normal angles and the index halfword.
//   Output channel out_valid/out_stall returns one decoded vertex per input
//   transaction, in order.
//   cfg_wr_en/cfg_wr_data load the 24-bit Q8.16 position scale; write it only
//   while no transaction is in flight.
//   Data path: an accepted input is captured in the input register, then in
//   the result register, which drives out_valid; decode logic sits between.
//   Throughput: one vertex per cycle while out_stall is low; each of the three
//   coordinate scalers has its own 16x24 multiplier and the normal unit has two
//   16x16 multipliers.
//   Reset (synchronous, active low) empties both stages and loads a scale of
//   1.0. When out_stall is high with a valid result, the result register holds;
//   the input register still fills once, after which in_stall rises.
// ----------------------------------------------------------------------------
module packed_vertex_decode_core
  import pvd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      cfg_wr_en,
  input  logic        [SCALE_W-1:0] cfg_wr_data,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic        [ANGLE_W-1:0] in_azimuth_angle,
  input  logic        [ANGLE_W-1:0] in_elevation_angle,
  input  logic        [HALF_W-1:0]  in_index_halfword,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [POS_W-1:0]   out_pos_x,
  output logic signed [POS_W-1:0]   out_pos_y,
  output logic signed [POS_W-1:0]   out_pos_z,
  output logic signed [NORM_W-1:0]  out_normal_x,
  output logic signed [NORM_W-1:0]  out_normal_y,
  output logic signed [NORM_W-1:0]  out_normal_z,
  output logic        [INDEX_W-1:0] out_vertex_index
);

  `include "packed_vertex_decode_core_assert.svh"

  localparam logic signed [NORM_W-1:0] NZ_MAX = NORM_W'(NORM_ONE);
  localparam logic signed [NORM_W-1:0] NZ_MIN = -NZ_MAX;

  logic [SCALE_W-1:0] scale_r;

  logic                      s1_valid_r;
  logic signed [COORD_W-1:0] s1_x_r;
  logic signed [COORD_W-1:0] s1_y_r;
  logic signed [COORD_W-1:0] s1_z_r;
  logic        [ANGLE_W-1:0] s1_az_r;
  logic        [ANGLE_W-1:0] s1_el_r;
  logic        [INDEX_W-1:0] s1_idx_r;

  logic                      out_valid_r;
  logic signed [POS_W-1:0]   pos_x_r;
  logic signed [POS_W-1:0]   pos_y_r;
  logic signed [POS_W-1:0]   pos_z_r;
  logic signed [NORM_W-1:0]  nrm_x_r;
  logic signed [NORM_W-1:0]  nrm_y_r;
  logic signed [NORM_W-1:0]  nrm_z_r;
  logic        [INDEX_W-1:0] idx_r;

  logic signed [POS_W-1:0]   pos_x_nxt;
  logic signed [POS_W-1:0]   pos_y_nxt;
  logic signed [POS_W-1:0]   pos_z_nxt;
  logic signed [NORM_W-1:0]  nrm_x_nxt;
  logic signed [NORM_W-1:0]  nrm_y_nxt;
  logic signed [NORM_W-1:0]  nrm_z_nxt;

  logic adv_out;
  logic adv_s1;
  logic in_take;

  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_s1   = !s1_valid_r || adv_out;
  assign in_stall = !adv_s1;
  assign in_take  = in_valid && adv_s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid_r <= in_valid;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x_r   <= in_coord_x;
      s1_y_r   <= in_coord_y;
      s1_z_r   <= in_coord_z;
      s1_az_r  <= in_azimuth_angle;
      s1_el_r  <= in_elevation_angle;
      s1_idx_r <= in_index_halfword[INDEX_W-1:0];
    end
  end

  pvd_pos_scale u_pos_x (.coord(s1_x_r), .scale(scale_r), .pos(pos_x_nxt));
  pvd_pos_scale u_pos_y (.coord(s1_y_r), .scale(scale_r), .pos(pos_y_nxt));
  pvd_pos_scale u_pos_z (.coord(s1_z_r), .scale(scale_r), .pos(pos_z_nxt));

  pvd_normal u_normal (
    .azimuth   (s1_az_r),
    .elevation (s1_el_r),
    .normal_x  (nrm_x_nxt),
    .normal_y  (nrm_y_nxt),
    .normal_z  (nrm_z_nxt)
  );

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
      nrm_x_r <= nrm_x_nxt;
      nrm_y_r <= nrm_y_nxt;
      nrm_z_r <= nrm_z_nxt;
      idx_r   <= s1_idx_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = pos_x_r;
  assign out_pos_y        = pos_y_r;
  assign out_pos_z        = pos_z_r;
  assign out_normal_x     = nrm_x_r;
  assign out_normal_y     = nrm_y_r;
  assign out_normal_z     = nrm_z_r;
  assign out_vertex_index = idx_r;

  `PVD_ASSERT(a_stage_moves, clk, rst_n, (s1_valid_r && adv_out) |=> out_valid_r, "item lost")
  `PVD_ASSERT(a_stall_full, clk, rst_n, in_stall |-> (out_stall && s1_valid_r), "stage free")
  `PVD_ASSERT(a_idx, clk, rst_n, (s1_valid_r && adv_out) |=> idx_r == $past(s1_idx_r), "idx")
  `PVD_ASSERT(a_nz_hi, clk, rst_n, out_valid_r |-> nrm_z_r <= NZ_MAX, "normal z high")
  `PVD_ASSERT(a_nz_lo, clk, rst_n, out_valid_r |-> nrm_z_r >= NZ_MIN, "normal z low")

endmodule
